>>> rtl/core/plcl_pkg.sv
package plcl_pkg;

  localparam int BREAKPOINTS    = 8;
  localparam int TABLE_COUNT    = 4;
  localparam int MV_W           = 13;
  localparam int CH_W           = 8;
  localparam int SEL_W          = 2;
  localparam int PROD_W         = MV_W + CH_W;
  localparam int BITS_PER_STAGE = 2;
  localparam int DIV_STAGES     = CH_W / BITS_PER_STAGE;

  typedef logic [MV_W-1:0] mv_t;
  typedef logic [CH_W-1:0] charge_t;

  localparam charge_t CHARGE_EMPTY = charge_t'(0);
  localparam charge_t CHARGE_FULL  = charge_t'(255);

  // breakpoint voltages in mV, one row per battery type
  localparam mv_t BP_MV [TABLE_COUNT][BREAKPOINTS] = '{
    '{13'd2800, 13'd3000, 13'd3100, 13'd3150, 13'd3250, 13'd3300, 13'd3400, 13'd3600},
    '{13'd2800, 13'd3000, 13'd3100, 13'd3150, 13'd3250, 13'd3300, 13'd3400, 13'd3600},
    '{13'd2800, 13'd3000, 13'd3100, 13'd3150, 13'd3250, 13'd3300, 13'd3400, 13'd3600},
    '{13'd2800, 13'd3000, 13'd3100, 13'd3200, 13'd3200, 13'd3300, 13'd3400, 13'd3600}
  };

  // charge at each breakpoint
  localparam charge_t BP_CH [TABLE_COUNT][BREAKPOINTS] = '{
    '{8'd0, 8'd25, 8'd50, 8'd96,  8'd160, 8'd200, 8'd225, 8'd255},
    '{8'd0, 8'd25, 8'd50, 8'd100, 8'd150, 8'd200, 8'd225, 8'd255},
    '{8'd0, 8'd25, 8'd50, 8'd100, 8'd150, 8'd200, 8'd225, 8'd255},
    '{8'd0, 8'd25, 8'd50, 8'd100, 8'd150, 8'd200, 8'd225, 8'd255}
  };

  // chosen segment: base charge, charge span, offset into segment, segment width
  typedef struct packed {
    charge_t clo;
    charge_t span;
    mv_t     dv;
    mv_t     dd;
  } seg_t;

  // divider state: base charge, remainder, shifted divisor, partial quotient
  typedef struct packed {
    charge_t           clo;
    logic [PROD_W-1:0] rem;
    logic [PROD_W-1:0] dsh;
    charge_t           quo;
  } quo_t;

endpackage

>>> rtl/core/plcl_seg_sel.sv
module plcl_seg_sel (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [plcl_pkg::SEL_W-1:0] battery_type,
  input  logic                      valid_i,
  output logic                      ready_o,
  input  logic [plcl_pkg::MV_W-1:0] voltage_i,
  output logic                      valid_o,
  input  logic                      ready_i,
  output plcl_pkg::seg_t            data_o
);
  import plcl_pkg::*;

  logic [SEL_W-1:0] sel;
  logic             found;
  mv_t              lo;
  mv_t              hi;
  seg_t             seg_nxt;
  seg_t             seg_r;
  logic             valid_r;

  always_comb begin
    sel = (int'(battery_type) >= TABLE_COUNT) ? SEL_W'(TABLE_COUNT - 1) : battery_type;
    found       = 1'b0;
    lo          = '0;
    hi          = '0;
    seg_nxt.clo  = CHARGE_EMPTY;
    seg_nxt.span = '0;
    seg_nxt.dv   = '0;
    seg_nxt.dd   = MV_W'(1);
    if (voltage_i <= BP_MV[sel][0]) begin
      seg_nxt.clo = CHARGE_EMPTY;
    end else if (voltage_i >= BP_MV[sel][BREAKPOINTS-1]) begin
      seg_nxt.clo = CHARGE_FULL;
    end else begin
      // first non-empty segment that holds the voltage
      for (int i = 0; i < BREAKPOINTS - 1; i++) begin
        lo = BP_MV[sel][i];
        hi = BP_MV[sel][i+1];
        if (!found && (hi > lo) && (voltage_i >= lo) && (voltage_i <= hi)) begin
          found        = 1'b1;
          seg_nxt.clo  = BP_CH[sel][i];
          seg_nxt.span = (BP_CH[sel][i+1] >= BP_CH[sel][i]) ?
                         (BP_CH[sel][i+1] - BP_CH[sel][i]) : '0;
          seg_nxt.dv   = voltage_i - lo;
          seg_nxt.dd   = hi - lo;
        end
      end
    end
  end

  assign ready_o = !valid_r || ready_i;
  assign valid_o = valid_r;
  assign data_o  = seg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready_o) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o && valid_i) begin
      seg_r <= seg_nxt;
    end
  end

endmodule

>>> rtl/core/plcl_mul.sv
module plcl_mul (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           valid_i,
  output logic           ready_o,
  input  plcl_pkg::seg_t data_i,
  output logic           valid_o,
  input  logic           ready_i,
  output plcl_pkg::quo_t data_o
);
  import plcl_pkg::*;

  logic [PROD_W-1:0] prod;
  quo_t              quo_nxt;
  quo_t              quo_r;
  logic              valid_r;

  assign prod = {{(PROD_W-CH_W){1'b0}}, data_i.span} * {{(PROD_W-MV_W){1'b0}}, data_i.dv};

  always_comb begin
    quo_nxt.clo = data_i.clo;
    quo_nxt.rem = prod;
    // divisor starts one place above the top quotient bit
    quo_nxt.dsh = {data_i.dd, {CH_W{1'b0}}};
    quo_nxt.quo = '0;
  end

  assign ready_o = !valid_r || ready_i;
  assign valid_o = valid_r;
  assign data_o  = quo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready_o) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o && valid_i) begin
      quo_r <= quo_nxt;
    end
  end

endmodule

>>> rtl/core/plcl_div_step.sv
module plcl_div_step (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           valid_i,
  output logic           ready_o,
  input  plcl_pkg::quo_t data_i,
  output logic           valid_o,
  input  logic           ready_i,
  output plcl_pkg::quo_t data_o
);
  import plcl_pkg::*;

  quo_t step_nxt;
  quo_t step_r;
  logic valid_r;

  // restoring division, a few quotient bits per stage
  always_comb begin
    step_nxt = data_i;
    for (int b = 0; b < BITS_PER_STAGE; b++) begin
      step_nxt.dsh = step_nxt.dsh >> 1;
      if (step_nxt.rem >= step_nxt.dsh) begin
        step_nxt.rem = step_nxt.rem - step_nxt.dsh;
        step_nxt.quo = {step_nxt.quo[CH_W-2:0], 1'b1};
      end else begin
        step_nxt.quo = {step_nxt.quo[CH_W-2:0], 1'b0};
      end
    end
  end

  assign ready_o = !valid_r || ready_i;
  assign valid_o = valid_r;
  assign data_o  = step_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready_o) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o && valid_i) begin
      step_r <= step_nxt;
    end
  end

endmodule

>>> rtl/core/piecewise_linear_charge_lookup.sv
// Battery charge lookup: each accepted voltage word (mV) gives one charge word, 0 empty to
// 255 full, by linear interpolation between fixed breakpoints of the battery type held in
// the configuration register. One word is taken every cycle while in_stall is low. Each
// word passes through seven register stages: segment select, multiply, four divider
// stages of two quotient bits each, and the output register. Every stage holds its own
// valid bit and fills bubbles on its own, so a stalled output only holds back input once
// all stages are full. Write battery_type only while no word is in flight.
module piecewise_linear_charge_lookup (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_write_en,
  input  logic [plcl_pkg::SEL_W-1:0] cfg_write_data,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [plcl_pkg::MV_W-1:0]  in_voltage_mv,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [plcl_pkg::CH_W-1:0]  out_charge_level
);
  import plcl_pkg::*;

  // battery type register
  logic [SEL_W-1:0] battery_type_r;

  // stage handshakes
  logic             in_ready;
  logic             seg_valid;
  seg_t             seg_data;
  logic             mul_ready;
  logic [DIV_STAGES:0] div_valid;
  logic [DIV_STAGES:0] div_ready;
  quo_t             div_data [DIV_STAGES+1];

  // output register
  logic             out_ready;
  logic             out_valid_r;
  charge_t          out_charge_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      battery_type_r <= '0;
    end else if (cfg_write_en) begin
      battery_type_r <= cfg_write_data;
    end
  end

  // stage 1: pick the segment and its operands
  plcl_seg_sel u_seg_sel (
    .clk          (clk),
    .rst_n        (rst_n),
    .battery_type (battery_type_r),
    .valid_i      (in_valid),
    .ready_o      (in_ready),
    .voltage_i    (in_voltage_mv),
    .valid_o      (seg_valid),
    .ready_i      (mul_ready),
    .data_o       (seg_data)
  );

  // stage 2: span times offset
  plcl_mul u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (seg_valid),
    .ready_o (mul_ready),
    .data_i  (seg_data),
    .valid_o (div_valid[0]),
    .ready_i (div_ready[0]),
    .data_o  (div_data[0])
  );

  // divider stages, quotient msb first
  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
    plcl_div_step u_div_step (
      .clk     (clk),
      .rst_n   (rst_n),
      .valid_i (div_valid[k]),
      .ready_o (div_ready[k]),
      .data_i  (div_data[k]),
      .valid_o (div_valid[k+1]),
      .ready_i (div_ready[k+1]),
      .data_o  (div_data[k+1])
    );
  end

  // output register: base charge plus interpolated step
  assign out_ready             = !out_valid_r || !out_stall;
  assign div_ready[DIV_STAGES] = out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_ready) begin
      out_valid_r <= div_valid[DIV_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready && div_valid[DIV_STAGES]) begin
      out_charge_r <= div_data[DIV_STAGES].clo + div_data[DIV_STAGES].quo;
    end
  end

  assign in_stall         = !in_ready;
  assign out_valid        = out_valid_r;
  assign out_charge_level = out_charge_r;

`ifndef SYNTHESIS
  // input only held back when every stage is full and the output is stalled
  a_stall_only_when_full : assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall && seg_valid && (&div_valid)))
    else $error("input stalled with room in the pipeline");

  // a chosen segment never has zero width
  a_nonzero_divisor : assert property (@(posedge clk) disable iff (!rst_n)
    seg_valid |-> (seg_data.dd != '0))
    else $error("zero segment width reached the divider");

  // divider finished: remainder below divisor, divisor back at segment width
  a_div_remainder : assert property (@(posedge clk) disable iff (!rst_n)
    div_valid[DIV_STAGES] |-> (div_data[DIV_STAGES].rem < div_data[DIV_STAGES].dsh))
    else $error("divider remainder not below divisor");

  // interpolated charge never wraps
  a_no_wrap : assert property (@(posedge clk) disable iff (!rst_n)
    div_valid[DIV_STAGES] |->
      ((CH_W+1)'(div_data[DIV_STAGES].clo) + (CH_W+1)'(div_data[DIV_STAGES].quo)
        <= (CH_W+1)'(CHARGE_FULL)))
    else $error("charge sum overflow");
`endif

endmodule
